// ===== sv/ccfr_pkg.sv =====
// Package for the COBS / CRC-8 frame receiver: sizes, status codes, result type
// and the CRC-8 byte step. No dependencies; imported by every ccfr module.
`default_nettype none
package ccfr_pkg;

    localparam int MAX_ENCODED_BYTES = 264;
    localparam int MAX_DECODED_BYTES = 260;
    localparam int MIN_FRAME_BYTES   = 4;

    localparam int ENC_W = $clog2(MAX_ENCODED_BYTES + 1);
    localparam int DEC_W = $clog2(MAX_DECODED_BYTES + 1);
    localparam int LEN_W = 16;
    localparam int POS_W = 9;
    localparam int CMP_W = (DEC_W > LEN_W + 1) ? DEC_W : LEN_W + 1;

    localparam logic [7:0] DELIM_BYTE = 8'h00;
    localparam logic [7:0] FULL_CODE  = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_GOOD      = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_LEN_MISM  = 3'd2,
        STATUS_CRC_MISM  = 3'd3,
        STATUS_BAD_COBS  = 3'd4,
        STATUS_OVERFLOW  = 3'd5
    } t_status;

    typedef struct packed {
        logic             out_kind;
        logic [7:0]       out_byte;
        logic [POS_W-1:0] byte_pos;
        t_status          frame_status;
        logic [7:0]       frame_type;
        logic [LEN_W-1:0] payload_length;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_result_req;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ccfr_in_stage.sv =====
// Input register of the frame receiver: holds one received byte until the
// decoder takes it. Depends on ccfr_pkg.
`default_nettype none
module ccfr_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_advance,
    output logic            o_held,
    output logic [7:0]      o_byte
);
    import ccfr_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_held  = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ccfr_decoder.sv =====
// COBS decode and CRC-8 check for one byte a cycle while i_advance is high, with all frame state.
// Depends on ccfr_pkg.
`default_nettype none
module ccfr_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    input  wire logic [7:0]  i_byte,
    output ccfr_pkg::t_result_req o_res
);
    import ccfr_pkg::*;

    logic [7:0]       r_rem,  n_rem;
    logic             r_full, n_full;
    logic [ENC_W-1:0] r_enc,  n_enc;
    logic [DEC_W-1:0] r_dec,  n_dec;
    logic [7:0]       r_crc,  n_crc;
    logic [7:0]       r_type, n_type;
    logic [LEN_W-1:0] r_len,  n_len;
    logic             r_bad,  n_bad;

    t_status    end_status;
    logic       take;
    logic [7:0] take_byte;

    always_comb begin
        if (r_bad || r_rem != 8'd0) begin
            end_status = STATUS_BAD_COBS;
        end else if (r_dec < DEC_W'(MIN_FRAME_BYTES)) begin
            end_status = STATUS_SHORT;
        end else if (CMP_W'(r_dec) != CMP_W'(r_len) + CMP_W'(MIN_FRAME_BYTES)) begin
            end_status = STATUS_LEN_MISM;
        end else if (r_crc != 8'd0) begin
            end_status = STATUS_CRC_MISM;
        end else begin
            end_status = STATUS_GOOD;
        end
    end

    always_comb begin
        n_rem  = r_rem;
        n_full = r_full;
        n_enc  = r_enc;
        n_dec  = r_dec;
        n_crc  = r_crc;
        n_type = r_type;
        n_len  = r_len;
        n_bad  = r_bad;
        take      = 1'b0;
        take_byte = 8'd0;
        o_res     = '0;
        if (i_advance) begin
            if (i_byte == DELIM_BYTE || r_enc >= ENC_W'(MAX_ENCODED_BYTES)) begin
                // end of frame, or overflow: report unless the frame is empty, and start over
                if (i_byte != DELIM_BYTE || r_enc != '0) begin
                    o_res.valid               = 1'b1;
                    o_res.data.out_kind       = KIND_END;
                    o_res.data.byte_pos       = POS_W'(r_dec);
                    o_res.data.frame_status   = (i_byte == DELIM_BYTE) ? end_status
                                                                       : STATUS_OVERFLOW;
                    o_res.data.frame_type     = r_type;
                    o_res.data.payload_length = r_len;
                end
                n_rem  = 8'd0;
                n_full = 1'b0;
                n_enc  = '0;
                n_dec  = '0;
                n_crc  = 8'd0;
                n_type = 8'd0;
                n_len  = '0;
                n_bad  = 1'b0;
            end else begin
                n_enc = r_enc + ENC_W'(1);
                if (r_rem == 8'd0) begin
                    // code byte: implied zero unless it opens the frame or the last block was full
                    take   = (r_enc != '0) && !r_full;
                    n_rem  = i_byte - 8'd1;
                    n_full = (i_byte == FULL_CODE);
                end else begin
                    take      = 1'b1;
                    take_byte = i_byte;
                    n_rem     = r_rem - 8'd1;
                end
                if (take) begin
                    if (r_dec >= DEC_W'(MAX_DECODED_BYTES)) begin
                        n_bad = 1'b1;
                    end else begin
                        if (r_dec == DEC_W'(0)) begin
                            n_type = take_byte;
                        end
                        if (r_dec == DEC_W'(1)) begin
                            n_len = {r_len[15:8], take_byte};
                        end
                        if (r_dec == DEC_W'(2)) begin
                            n_len = {take_byte, r_len[7:0]};
                        end
                        n_crc = crc8_step(r_crc, take_byte);
                        n_dec = r_dec + DEC_W'(1);
                        o_res.valid             = 1'b1;
                        o_res.data.out_kind     = KIND_DATA;
                        o_res.data.out_byte     = take_byte;
                        o_res.data.byte_pos     = POS_W'(r_dec);
                        o_res.data.frame_status = STATUS_GOOD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 8'd0;
            r_full <= 1'b0;
            r_enc  <= '0;
            r_dec  <= '0;
            r_crc  <= 8'd0;
            r_type <= 8'd0;
            r_len  <= '0;
            r_bad  <= 1'b0;
        end else begin
            r_rem  <= n_rem;
            r_full <= n_full;
            r_enc  <= n_enc;
            r_dec  <= n_dec;
            r_crc  <= n_crc;
            r_type <= n_type;
            r_len  <= n_len;
            r_bad  <= n_bad;
        end
    end

    a_enc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enc <= ENC_W'(MAX_ENCODED_BYTES))
        else $error("encoded count past limit");

    a_dec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec <= DEC_W'(MAX_DECODED_BYTES))
        else $error("decoded count past limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.out_kind == KIND_END)
        |=> (r_enc == '0 && r_dec == '0 && r_crc == 8'd0 && !r_bad))
        else $error("frame state not cleared after end item");

    a_dec_follows_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enc == '0) |-> (r_dec == '0 && r_rem == 8'd0))
        else $error("decoded bytes without encoded bytes");

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.out_kind == KIND_DATA)
        |-> (o_res.data.frame_status == STATUS_GOOD && o_res.data.frame_type == 8'd0))
        else $error("data item carries end fields");

endmodule
`default_nettype wire

// ===== sv/ccfr_out_reg.sv =====
// Result register of the frame receiver: holds one request until the
// downstream side takes it. Depends on ccfr_pkg.
`default_nettype none
module ccfr_out_reg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire ccfr_pkg::t_result_req i_res,
    input  wire logic        i_ready,
    output logic             o_free,
    output logic             o_valid,
    output ccfr_pkg::t_result o_data
);
    import ccfr_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_data <= i_res.data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/cobs_crc8_frame_receiver_unit.sv =====
// Top level of the COBS / CRC-8 frame receiver: input register, decoder and
// result register. Depends on ccfr_pkg, ccfr_in_stage, ccfr_decoder, ccfr_out_reg.
//
// Usage:
//   Input channel i_valid / o_ready / i_rx_byte carries received encoded bytes;
//   a zero byte ends a frame. Output channel o_valid / i_ready carries one
//   request per decoded byte (out_kind 0, byte and position) and one end request
//   per nonempty frame (out_kind 1, status, type, length, decoded count).
//   A code byte that stands for no zero, an empty frame's delimiter and a byte
//   past the decoded limit give no request.
//   An accepted byte waits in the input register, is decoded combinationally,
//   and its request is loaded into the result register, which drives o_valid.
//   Throughput: one byte per cycle; the decoder takes one byte a cycle from the
//   input register whenever the result register is empty or being emptied.
//   While i_ready is low with a request presented, the result register holds it,
//   the decoder stops, and o_ready drops once the input register is full.
//   Reset (i_rst_n low at a clock edge) clears both registers' valid flags and
//   all frame state, so the block waits for the start of a new frame.
`default_nettype none
module cobs_crc8_frame_receiver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [ccfr_pkg::POS_W-1:0] o_byte_pos,
    output logic [2:0]       o_frame_status,
    output logic [7:0]       o_frame_type,
    output logic [ccfr_pkg::LEN_W-1:0] o_payload_length
);
    import ccfr_pkg::*;

    logic        held;
    logic [7:0]  held_byte;
    logic        out_free;
    logic        advance;
    t_result_req dec_res;
    t_result     out_data;

    // move a byte into the decoder only when its result has a place to go
    assign advance = held && out_free;

    ccfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_advance (advance),
        .o_held    (held),
        .o_byte    (held_byte)
    );

    ccfr_decoder u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (held_byte),
        .o_res     (dec_res)
    );

    ccfr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (dec_res),
        .i_ready (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_data  (out_data)
    );

    assign o_out_kind       = out_data.out_kind;
    assign o_out_byte       = out_data.out_byte;
    assign o_byte_pos       = out_data.byte_pos;
    assign o_frame_status   = out_data.frame_status;
    assign o_frame_type     = out_data.frame_type;
    assign o_payload_length = out_data.payload_length;

endmodule
`default_nettype wire
